/* design/dbrsf_pkg.sv */
// ----------------------------------------------------------------------------
// dbrsf_pkg: shared types and constants of the doorbell receive filter
// Word layouts, action codes, the fixed device-ID table and its lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dbrsf_pkg;

  localparam int TABLE_SIZE   = 16;
  localparam int NODE_COUNT   = 16;
  localparam int SEARCH_LIMIT = (NODE_COUNT > TABLE_SIZE) ? TABLE_SIZE : NODE_COUNT;
  localparam int IDX_W        = $clog2(TABLE_SIZE);
  localparam int LOC_W        = IDX_W + 1;
  localparam int CODE_W       = 16;
  localparam int PROC_W       = 31;
  localparam int SEQ_W        = 64;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_ACK_CODE  = 1'b0;
  localparam logic REG_DATA_CODE = 1'b1;

  localparam logic [CODE_W-1:0] ACK_CODE_RST  = 16'h0001;
  localparam logic [CODE_W-1:0] DATA_CODE_RST = 16'h0002;

  // Device IDs of locations 1..16
  localparam logic [CODE_W-1:0] DEV_TABLE [TABLE_SIZE] = '{
    16'h001e, 16'h001d, 16'h001c, 16'h001b, 16'h001a, 16'h0019, 16'h0018, 16'h0000,
    16'h0000, 16'h0012, 16'h0013, 16'h0014, 16'h000e, 16'h0015, 16'h0016, 16'h0017
  };

  typedef enum logic [2:0] {
    ACT_ACK_CLEARED = 3'd0,
    ACT_ACCEPTED    = 3'd1,
    ACT_STALE       = 3'd2,
    ACT_UNKNOWN_DB  = 3'd3,
    ACT_UNKNOWN_SRC = 3'd4,
    ACT_SEND_MARKED = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    OP_REPORT   = 2'd0,
    OP_SET_BUSY = 2'd1,
    OP_CLR_BUSY = 2'd2,
    OP_DATA     = 2'd3
  } op_t;

  typedef struct packed {
    logic               opcode;
    logic [CODE_W-1:0]  source_id;
    logic [CODE_W-1:0]  doorbell_info;
    logic [PROC_W-1:0]  header_process;
    logic [SEQ_W-1:0]   header_sequence;
    logic [LOC_W-1:0]   send_location;
  } in_word_t;

  typedef struct packed {
    action_t                 action;
    logic [LOC_W-1:0]        source_location;
    logic                    reply_ack;
    logic [TABLE_SIZE-1:0]   busy_mask;
  } out_word_t;

  // Decoded item, carried from the lookup cycle to the update cycle
  typedef struct packed {
    op_t               op;
    action_t           action;
    logic [LOC_W-1:0]  loc;
    logic [IDX_W-1:0]  idx;
    logic [PROC_W-1:0] proc;
    logic [SEQ_W-1:0]  seq;
  } ctx_t;

  // One peer entry of the state RAM
  typedef struct packed {
    logic [PROC_W-1:0] proc;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  // Lowest matching location 1..SEARCH_LIMIT, 0 when none
  function automatic logic [LOC_W-1:0] find_location(input logic [CODE_W-1:0] id);
    logic [LOC_W-1:0] loc;
    loc = '0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (i < SEARCH_LIMIT && DEV_TABLE[i] == id) begin
        loc = LOC_W'(i + 1);
      end
    end
    return loc;
  endfunction

endpackage
`default_nettype wire

/* design/dbrsf_ram.sv */
// ----------------------------------------------------------------------------
// dbrsf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dbrsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/dbrsf_decode.sv */
// ----------------------------------------------------------------------------
// dbrsf_decode: classify an incoming word and look up its location
// Produces the operation, location and preliminary action of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dbrsf_decode
  import dbrsf_pkg::*;
(
  input  wire in_word_t          word,
  input  wire logic [CODE_W-1:0] ack_code,
  input  wire logic [CODE_W-1:0] data_code,
  output ctx_t                   ctx
);

  logic [LOC_W-1:0] found;
  logic [LOC_W-1:0] loc;

  assign found = find_location(word.source_id);

  always_comb begin
    loc        = '0;
    ctx.op     = OP_REPORT;
    ctx.action = ACT_UNKNOWN_SRC;
    if (word.opcode) begin
      if (word.send_location != '0 && word.send_location <= LOC_W'(SEARCH_LIMIT)) begin
        loc        = word.send_location;
        ctx.op     = OP_SET_BUSY;
        ctx.action = ACT_SEND_MARKED;
      end
    end else if (word.doorbell_info == ack_code) begin
      // equal codes resolve as acknowledge
      if (found != '0) begin
        loc        = found;
        ctx.op     = OP_CLR_BUSY;
        ctx.action = ACT_ACK_CLEARED;
      end
    end else if (word.doorbell_info == data_code) begin
      if (found != '0) begin
        loc        = found;
        ctx.op     = OP_DATA;
        ctx.action = ACT_ACCEPTED;
      end
    end else begin
      loc        = found;
      ctx.action = ACT_UNKNOWN_DB;
    end
    ctx.loc  = loc;
    ctx.idx  = IDX_W'(loc - LOC_W'(1));
    ctx.proc = word.header_process;
    ctx.seq  = word.header_sequence;
  end

endmodule
`default_nettype wire

/* design/dbrsf_update.sv */
// ----------------------------------------------------------------------------
// dbrsf_update: modify one peer entry and the busy flags
// Applies process-ID tracking and the sequence check, forms the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dbrsf_update
  import dbrsf_pkg::*;
(
  input  wire ctx_t                  ctx,
  input  wire entry_t                rd_entry,
  input  wire logic                  entry_valid,
  input  wire logic [TABLE_SIZE-1:0] flags_in,
  output logic [TABLE_SIZE-1:0]      flags_out,
  output logic                       wr_en,
  output entry_t                     wr_entry,
  output out_word_t                  result
);

  entry_t                stored;
  logic [SEQ_W-1:0]      base_seq;
  logic [TABLE_SIZE-1:0] bit_sel;

  // entries never written read as all zero
  assign stored = entry_valid ? rd_entry : '0;

  always_comb begin
    bit_sel          = '0;
    bit_sel[ctx.idx] = 1'b1;
  end

  // a changed process ID restarts the sequence at zero
  assign base_seq = (stored.proc != '0 && stored.proc != ctx.proc) ? '0 : stored.seq;

  always_comb begin
    flags_out              = flags_in;
    wr_en                  = 1'b0;
    wr_entry               = stored;
    result.action          = ctx.action;
    result.source_location = ctx.loc;
    result.reply_ack       = 1'b0;
    case (ctx.op)
      OP_SET_BUSY: flags_out = flags_in | bit_sel;
      OP_CLR_BUSY: flags_out = flags_in & ~bit_sel;
      OP_DATA: begin
        wr_en            = 1'b1;
        wr_entry.proc    = ctx.proc;
        result.reply_ack = 1'b1;
        if (ctx.seq > base_seq) begin
          wr_entry.seq  = ctx.seq;
          result.action = ACT_ACCEPTED;
        end else begin
          wr_entry.seq  = base_seq;
          result.action = ACT_STALE;
        end
      end
      default: ;
    endcase
    result.busy_mask = flags_out;
  end

endmodule
`default_nettype wire

/* design/doorbell_receive_seq_filter_unit.sv */
// ----------------------------------------------------------------------------
// doorbell_receive_seq_filter_unit: inbound doorbell filter top level
// Source lookup, per-peer process/sequence tracking and busy flags.
// ----------------------------------------------------------------------------
// Lookup then update: start is taken while busy is low, and the peer
// entry is read from the state RAM at that edge. busy then stays high for one
// cycle, in which the entry is modified; the write-back and the result word
// both land at the edge that ends it. out_strobe is high for exactly one cycle,
// the one right after busy, and the result must be taken at the edge that ends
// it, the second edge after the accepting one: there is no back-pressure.
// A new item may be started in the cycle the result is shown. The rate is set
// by the registered read data of the state RAM.
// No clearing pass is needed after reset: per-entry valid bits make unwritten
// peer entries read as zero. Write the doorbell codes only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module doorbell_receive_seq_filter_unit
  import dbrsf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // item channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_word_t              in_word,
  // result channel
  output logic                       out_strobe,
  output out_word_t                  out_word,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  // configuration registers
  logic [CODE_W-1:0]     ack_code_r;
  logic [CODE_W-1:0]     ack_code_nxt;
  logic [CODE_W-1:0]     data_code_r;
  logic [CODE_W-1:0]     data_code_nxt;

  // control
  logic                  accept;
  logic                  busy_r;
  logic                  busy_nxt;
  logic                  out_strobe_r;
  logic                  out_strobe_nxt;
  logic [TABLE_SIZE-1:0] flags_r;
  logic [TABLE_SIZE-1:0] flags_nxt;
  logic [TABLE_SIZE-1:0] valid_r;
  logic [TABLE_SIZE-1:0] valid_nxt;

  // payload
  ctx_t                  dec_ctx;
  ctx_t                  ctx_r;
  out_word_t             out_word_r;
  entry_t                rd_entry;
  entry_t                wr_entry;
  logic                  upd_we;
  logic [TABLE_SIZE-1:0] upd_flags;
  out_word_t             upd_result;

  assign accept = start && !busy_r;

  // --------------------------------------------------------------------------
  // Configuration port: pready always high, write on the access cycle
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    ack_code_nxt  = ack_code_r;
    data_code_nxt = data_code_r;
    if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_ACK_CODE:  ack_code_nxt  = pwdata[CODE_W-1:0];
        REG_DATA_CODE: data_code_nxt = pwdata[CODE_W-1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ACK_CODE:  prdata[CODE_W-1:0] = ack_code_r;
      REG_DATA_CODE: prdata[CODE_W-1:0] = data_code_r;
    endcase
  end

  // --------------------------------------------------------------------------
  // Lookup cycle: decode the word and launch the peer entry read
  // --------------------------------------------------------------------------
  dbrsf_decode u_decode (
    .word      (in_word),
    .ack_code  (ack_code_r),
    .data_code (data_code_r),
    .ctx       (dec_ctx)
  );

  // The write of one item (update cycle) always lands before the read of the
  // next (its accept edge), so no forwarding path is required.
  dbrsf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_SIZE)
  ) u_peer_ram (
    .clk   (clk),
    .we    (busy_r && upd_we),
    .waddr (ctx_r.idx),
    .wdata (wr_entry),
    .raddr (dec_ctx.idx),
    .rdata (rd_entry)
  );

  // --------------------------------------------------------------------------
  // Update cycle: modify the entry, write back, form the result
  // --------------------------------------------------------------------------
  dbrsf_update u_update (
    .ctx         (ctx_r),
    .rd_entry    (rd_entry),
    .entry_valid (valid_r[ctx_r.idx]),
    .flags_in    (flags_r),
    .flags_out   (upd_flags),
    .wr_en       (upd_we),
    .wr_entry    (wr_entry),
    .result      (upd_result)
  );

  // busy covers exactly the cycle between accept and write-back
  assign busy_nxt       = accept;
  assign out_strobe_nxt = busy_r;
  assign flags_nxt      = busy_r ? upd_flags : flags_r;

  always_comb begin
    valid_nxt = valid_r;
    if (busy_r && upd_we) begin
      valid_nxt[ctx_r.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      flags_r      <= '0;
      valid_r      <= '0;
      ack_code_r   <= ACK_CODE_RST;
      data_code_r  <= DATA_CODE_RST;
    end else begin
      busy_r       <= busy_nxt;
      out_strobe_r <= out_strobe_nxt;
      flags_r      <= flags_nxt;
      valid_r      <= valid_nxt;
      ack_code_r   <= ack_code_nxt;
      data_code_r  <= data_code_nxt;
    end
  end

  // hold the decoded word and the result word between updates
  always_ff @(posedge clk) begin
    if (accept) begin
      ctx_r <= dec_ctx;
    end
    if (busy_r) begin
      out_word_r <= upd_result;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule
`default_nettype wire

/* design/dbrsf_checker.sv */
// ----------------------------------------------------------------------------
// dbrsf_checker: port-level checks of the doorbell receive filter
// Watches handshake timing and result consistency at the top level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dbrsf_checker
  import dbrsf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_strobe,
  input wire out_word_t out_word
);

  // an accepted word produces its result strobe, via the busy register and then the strobe register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_strobe)
    else $error("result word missing two cycles after accept");

  // accept always locks out the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // one result per word, never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  // reply requested exactly on matched data doorbells
  a_reply_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_word.reply_ack ==
                    (out_word.action == ACT_ACCEPTED || out_word.action == ACT_STALE)))
    else $error("reply_ack inconsistent with action");

  // unknown source never carries a location
  a_unknown_loc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.action == ACT_UNKNOWN_SRC) |-> (out_word.source_location == '0))
    else $error("unknown source reported with a location");

endmodule

bind doorbell_receive_seq_filter_unit dbrsf_checker u_dbrsf_checker (.*);
`default_nettype wire
